// ===== design/pap_pkg.sv =====
// Shared types and constants for the point axis rotation core.
package pap_pkg;

  localparam int TRIG_WIDTH = 17;
  localparam int Q15_WIDTH  = 15;
  localparam int QW_WIDTH   = 17;
  localparam int QW_PROD_WIDTH = 2 * QW_WIDTH;

  localparam logic [QW_WIDTH-1:0] QW_A    = 17'd102944;
  localparam logic [QW_WIDTH-1:0] QW_B    = 17'd42047;
  localparam logic [QW_WIDTH-1:0] QW_C    = 17'd4640;
  localparam logic [QW_WIDTH-1:0] QW_ONE  = 17'd65536;
  localparam logic [Q15_WIDTH-1:0] Q15_MAX = 15'd32767;

  localparam int CFG_INDEX_WIDTH = 1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS  = 1'd1;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z,
    AXIS_NONE
  } axis_t;

  typedef enum logic [1:0] {
    PH_SQUARE,
    PH_INNER,
    PH_MIDDLE,
    PH_OUTER
  } qw_phase_t;

  typedef struct packed {
    logic signed [TRIG_WIDTH-1:0] sin_v;
    logic signed [TRIG_WIDTH-1:0] cos_v;
  } trig_t;

endpackage

// ===== design/pap_trig.sv =====
// Quarter-wave sine unit: evaluates S(f) and S(1-f) on one shared multiplier.
module pap_trig #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ANGLE_WIDTH-1:0]          angle,
  output logic                            busy,
  output logic [pap_pkg::Q15_WIDTH-1:0]   sine_f,
  output logic [pap_pkg::Q15_WIDTH-1:0]   sine_r
);

  localparam int QW = pap_pkg::QW_WIDTH;
  localparam int PW = pap_pkg::QW_PROD_WIDTH;

  logic [3:0]    step;
  logic [QW-1:0] x2;
  logic [PW-1:0] prod;

  logic [23:0]   f_wide;
  logic [15:0]   f;
  logic [QW-1:0] u;
  logic [QW-1:0] prod_hi;
  logic [QW-1:0] ma;
  logic [QW-1:0] mb;
  logic [QW:0]   q_sum;
  logic [QW-1:0] q_half;
  logic [pap_pkg::Q15_WIDTH-1:0] q15;

  assign f_wide  = 24'(angle[ANGLE_WIDTH-3:0]) << (26 - ANGLE_WIDTH);
  assign f       = f_wide[23:8];
  assign u       = step[2] ? (pap_pkg::QW_ONE - {1'b0, f}) : {1'b0, f};
  assign prod_hi = prod[32:16];

  always_comb begin
    case (pap_pkg::qw_phase_t'(step[1:0]))
      pap_pkg::PH_SQUARE: begin
        ma = u;
        mb = u;
      end
      pap_pkg::PH_INNER: begin
        ma = pap_pkg::QW_C;
        mb = prod_hi;
      end
      pap_pkg::PH_MIDDLE: begin
        ma = x2;
        mb = pap_pkg::QW_B - prod_hi;
      end
      pap_pkg::PH_OUTER: begin
        ma = u;
        mb = pap_pkg::QW_A - prod_hi;
      end
      default: begin
        ma = u;
        mb = u;
      end
    endcase
  end

  assign q_sum  = {1'b0, prod_hi} + (QW+1)'(1);
  assign q_half = q_sum[QW:1];
  assign q15    = (q_half > QW'(pap_pkg::Q15_MAX)) ? pap_pkg::Q15_MAX
                                                   : q_half[pap_pkg::Q15_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      step   <= '0;
      sine_f <= '0;
      sine_r <= pap_pkg::Q15_MAX;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 4'd1;
      if (step == 4'd4) begin
        sine_f <= q15;
      end
      if (step == 4'd8) begin
        sine_r <= q15;
        busy   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (pap_pkg::qw_phase_t'(step[1:0]) == pap_pkg::PH_INNER) begin
      x2 <= prod_hi;
    end
  end

endmodule

// ===== design/pap_rotate.sv =====
// Point datapath: input register, product register, rounded result register.
module pap_rotate #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          hold_input,
  input  pap_pkg::axis_t                axis,
  input  pap_pkg::trig_t                trig,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  input  logic                          last_point,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          last_out
);

  localparam int TW = pap_pkg::TRIG_WIDTH;
  localparam int PW = COORD_WIDTH + TW;
  localparam int SW = PW + 1;

  logic                          v1;
  logic signed [COORD_WIDTH-1:0] x1;
  logic signed [COORD_WIDTH-1:0] y1;
  logic signed [COORD_WIDTH-1:0] z1;
  logic                          last1;

  logic                          v2;
  logic signed [PW-1:0]          prod_ac;
  logic signed [PW-1:0]          prod_bs;
  logic signed [PW-1:0]          prod_as;
  logic signed [PW-1:0]          prod_bc;
  logic signed [COORD_WIDTH-1:0] pass2;
  logic                          last2;

  logic adv1;
  logic adv2;
  logic adv3;
  logic accept;

  logic signed [COORD_WIDTH-1:0] op_a;
  logic signed [COORD_WIDTH-1:0] op_b;
  logic signed [COORD_WIDTH-1:0] op_p;
  logic signed [TW-1:0]          c_eff;
  logic signed [TW-1:0]          s_eff;

  logic signed [SW-1:0]          sum_a;
  logic signed [SW-1:0]          sum_b;
  logic signed [COORD_WIDTH-1:0] res_a;
  logic signed [COORD_WIDTH-1:0] res_b;

  function automatic logic signed [COORD_WIDTH-1:0] round_sat(input logic signed [SW-1:0] acc);
    logic signed [SW-1:0] r;
    logic [SW-COORD_WIDTH:0] top;
    begin
      r   = (acc + SW'(16384)) >>> 15;
      top = r[SW-1:COORD_WIDTH-1];
      if (top == '0 || top == '1) begin
        round_sat = r[COORD_WIDTH-1:0];
      end else if (r[SW-1]) begin
        round_sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
        round_sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
    end
  endfunction

  assign adv3     = !out_valid || !out_stall;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_stall = hold_input || !adv1;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    c_eff = trig.cos_v;
    s_eff = trig.sin_v;
    op_a  = x1;
    op_b  = y1;
    op_p  = z1;
    case (axis)
      pap_pkg::AXIS_X: begin
        op_a = y1;
        op_b = z1;
        op_p = x1;
      end
      pap_pkg::AXIS_Y: begin
        op_a  = x1;
        op_b  = z1;
        op_p  = y1;
        s_eff = -trig.sin_v;
      end
      pap_pkg::AXIS_Z: begin
        op_a = x1;
        op_b = y1;
        op_p = z1;
      end
      default: begin
        c_eff = TW'(32768);
        s_eff = '0;
      end
    endcase
  end

  assign sum_a = SW'(prod_ac) + SW'(prod_bs);
  assign sum_b = SW'(prod_bc) - SW'(prod_as);
  assign res_a = round_sat(sum_a);
  assign res_b = round_sat(sum_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= accept;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1    <= in_x;
      y1    <= in_y;
      z1    <= in_z;
      last1 <= last_point;
    end
    if (adv2 && v1) begin
      prod_ac <= PW'(op_a) * PW'(c_eff);
      prod_bs <= PW'(op_b) * PW'(s_eff);
      prod_as <= PW'(op_a) * PW'(s_eff);
      prod_bc <= PW'(op_b) * PW'(c_eff);
      pass2   <= op_p;
      last2   <= last1;
    end
    if (adv3 && v2) begin
      last_out <= last2;
      case (axis)
        pap_pkg::AXIS_X: begin
          out_x <= pass2;
          out_y <= res_a;
          out_z <= res_b;
        end
        pap_pkg::AXIS_Y: begin
          out_x <= res_a;
          out_y <= pass2;
          out_z <= res_b;
        end
        default: begin
          out_x <= res_a;
          out_y <= res_b;
          out_z <= pass2;
        end
      endcase
    end
  end

endmodule

// ===== design/point_axis_rotation_core.sv =====
// Top level of the point axis rotation core: configuration registers, trig unit, datapath.
// Rotates Q7.8 points about the x, y or z axis by a binary angle, one point per clock
// while out_stall is low, through three registers (input register, product register,
// result register; four signed multipliers work in parallel). Sine and cosine are held
// in registers and recomputed by a small unit with one shared multiplier after each
// angle write: in_stall stays high in the write cycle and while it works. Axis writes
// take effect at once. Writing axis code three passes points through unchanged.
module point_axis_rotation_core #(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [pap_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [ANGLE_WIDTH-1:0]                cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_WIDTH-1:0]         in_x,
  input  logic signed [COORD_WIDTH-1:0]         in_y,
  input  logic signed [COORD_WIDTH-1:0]         in_z,
  input  logic                                  last_point,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [COORD_WIDTH-1:0]         out_x,
  output logic signed [COORD_WIDTH-1:0]         out_y,
  output logic signed [COORD_WIDTH-1:0]         out_z,
  output logic                                  last_out
);

  localparam int TW = pap_pkg::TRIG_WIDTH;

  logic [ANGLE_WIDTH-1:0]        rotation_angle;
  pap_pkg::axis_t                rotation_axis;

  logic                          angle_write;
  logic                          trig_busy;
  logic [pap_pkg::Q15_WIDTH-1:0] sine_f;
  logic [pap_pkg::Q15_WIDTH-1:0] sine_r;
  logic signed [TW-1:0]          sf_pos;
  logic signed [TW-1:0]          sr_pos;
  logic [1:0]                    quad;
  pap_pkg::trig_t                trig;

  assign angle_write = cfg_write && (cfg_index == pap_pkg::REG_ANGLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_angle <= '0;
      rotation_axis  <= pap_pkg::AXIS_X;
    end else if (cfg_write) begin
      case (cfg_index)
        pap_pkg::REG_ANGLE: rotation_angle <= cfg_data;
        pap_pkg::REG_AXIS:  rotation_axis  <= pap_pkg::axis_t'(cfg_data[1:0]);
        default: begin
        end
      endcase
    end
  end

  pap_trig #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_trig (
    .clk   (clk),
    .rst   (rst),
    .start (angle_write),
    .angle (rotation_angle),
    .busy  (trig_busy),
    .sine_f(sine_f),
    .sine_r(sine_r)
  );

  assign sf_pos = $signed({2'b00, sine_f});
  assign sr_pos = $signed({2'b00, sine_r});
  assign quad   = rotation_angle[ANGLE_WIDTH-1:ANGLE_WIDTH-2];

  always_comb begin
    case (quad)
      2'd0: begin
        trig.sin_v = sf_pos;
        trig.cos_v = sr_pos;
      end
      2'd1: begin
        trig.sin_v = sr_pos;
        trig.cos_v = -sf_pos;
      end
      2'd2: begin
        trig.sin_v = -sf_pos;
        trig.cos_v = -sr_pos;
      end
      default: begin
        trig.sin_v = -sr_pos;
        trig.cos_v = sf_pos;
      end
    endcase
  end

  pap_rotate #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .hold_input(trig_busy || angle_write),
    .axis      (rotation_axis),
    .trig      (trig),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .last_point(last_point),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .last_out  (last_out)
  );

endmodule
